@@ sv/hpsa_pkg.sv @@
package hpsa_pkg;

  localparam logic signed [33:0] LIM = 34'sh0_FFFF_FFFF;
  localparam logic [62:0] ACC_MAX = {63{1'b1}};
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_SPOT_START  = 3'd0,
    CFG_VAR_START   = 3'd1,
    CFG_STRIKE      = 3'd2,
    CFG_DRIFT       = 3'd3,
    CFG_REVERSION   = 3'd4,
    CFG_VAR_TARGET  = 3'd5,
    CFG_VOL_OF_VOL  = 3'd6,
    CFG_SQRT_STEP   = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MUL_DWV = 4'd0,
    MUL_DWI = 4'd1,
    MUL_T1  = 4'd2,
    MUL_DWS = 4'd3,
    MUL_DVA = 4'd4,
    MUL_VB  = 4'd5,
    MUL_DV  = 4'd6,
    MUL_DSD = 4'd7,
    MUL_E   = 4'd8,
    MUL_DS  = 4'd9
  } mul_op_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SQ_C   = 7'b0000010,
    ST_SQ_V   = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_UPDATE = 7'b0010000,
    ST_PAYOFF = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    store_c;
    logic    store_sv;
    logic    mul_issue;
    logic    mul_write;
    mul_op_t mul_op;
    logic    update;
    logic    payoff;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic sq_done;
    logic pend;
    logic rend;
    logic out_free;
  } status_t;

  function automatic logic signed [32:0] clamp_lim(input logic signed [33:0] x);
    logic signed [33:0] r;
    r = x;
    if (x > LIM) r = LIM;
    if (x < -LIM) r = -LIM;
    return r[32:0];
  endfunction

endpackage

@@ sv/hpsa_in_if.sv @@
interface hpsa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_var;
  logic signed [15:0] normal_indep;
  logic signed [15:0] correlation;
  logic               path_end;
  logic               run_end;

  modport source(output valid, normal_var, normal_indep, correlation, path_end, run_end,
                 input ready);
  modport sink(input valid, normal_var, normal_indep, correlation, path_end, run_end,
               output ready);
endinterface

@@ sv/hpsa_out_if.sv @@
interface hpsa_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] call_total;
  logic [62:0] put_total;
  logic [31:0] paths_total;

  modport source(output valid, call_total, put_total, paths_total, input ready);
  modport sink(input valid, call_total, put_total, paths_total, output ready);
endinterface

@@ sv/hpsa_isqrt.sv @@
module hpsa_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] xr;
  logic [33:0] rem;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [33:0] rem_next;
  logic [31:0] root_next;

  // one root bit per cycle, two radicand bits shifted in
  always_comb begin
    rem_sh = {rem, xr[63:62]};
    trial  = {2'b00, root, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = 34'(rem_sh - trial);
      root_next = {root[30:0], 1'b1};
    end else begin
      rem_next  = rem_sh[33:0];
      root_next = {root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        xr   <= x;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= rem_next;
        root <= root_next;
        xr   <= {xr[61:0], 2'b00};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/hpsa_datapath.sv @@
module hpsa_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [15:0] in_nv,
  input  logic signed [15:0] in_ni,
  input  logic signed [15:0] in_rho,
  input  logic               in_pend,
  input  logic               in_rend,
  input  hpsa_pkg::cmd_t     cmd,
  output hpsa_pkg::status_t  status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [62:0]        out_call,
  output logic [62:0]        out_put,
  output logic [31:0]        out_paths
);

  // configuration
  logic [30:0]        spot_start, var_start, strike_price, reversion, var_target;
  logic [30:0]        vol_of_vol, sqrt_step;
  logic signed [31:0] drift;

  // step state
  logic signed [15:0] nv, ni, rho;
  logic               pend, rend;
  logic signed [31:0] spot;
  logic [31:0]        variance;
  logic               path_open;
  logic [15:0]        c;
  logic [31:0]        sv;
  logic signed [32:0] dw_v, dw_i, t1, dw_s, dva, vb, dv, dsd, e, ds;
  logic [62:0]        call_acc, put_acc;
  logic [31:0]        path_counter;

  // multiplier
  logic signed [33:0] op_a, op_b, abs_a, abs_b;
  logic [63:0]        prod, shifted;
  logic               prod_neg;
  logic [31:0]        mag;
  logic signed [32:0] res;

  // square root feed
  logic               sq_load;
  logic [63:0]        sq_x;
  logic [31:0]        sq_root;
  logic signed [31:0] rho_sq;
  logic [31:0]        c_arg;

  // update and payoff
  logic signed [33:0] ns_sum, nvar_sum, diff;
  logic [31:0]        pay;
  logic [63:0]        call_sum, put_sum;

  assign rho_sq  = in_rho * in_rho;
  assign c_arg   = 32'(32'sd1073741824 - rho_sq);
  assign sq_load = cmd.capture | cmd.store_c;
  assign sq_x    = cmd.capture ? 64'(c_arg) : (64'(variance) << FRAC_BITS);

  hpsa_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .load (sq_load),
    .x    (sq_x),
    .done (status.sq_done),
    .root (sq_root)
  );

  assign status.pend     = pend;
  assign status.rend     = rend;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      spot_start   <= 31'd6553600;
      var_start    <= 31'd2621;
      strike_price <= 31'd6553600;
      drift        <= '0;
      reversion    <= '0;
      var_target   <= 31'd2621;
      vol_of_vol   <= '0;
      sqrt_step    <= 31'd65536;
    end else if (cfg_we) begin
      case (hpsa_pkg::cfg_reg_t'(cfg_index))
        hpsa_pkg::CFG_SPOT_START: spot_start   <= cfg_data[30:0];
        hpsa_pkg::CFG_VAR_START:  var_start    <= cfg_data[30:0];
        hpsa_pkg::CFG_STRIKE:     strike_price <= cfg_data[30:0];
        hpsa_pkg::CFG_DRIFT:      drift        <= cfg_data;
        hpsa_pkg::CFG_REVERSION:  reversion    <= cfg_data[30:0];
        hpsa_pkg::CFG_VAR_TARGET: var_target   <= cfg_data[30:0];
        hpsa_pkg::CFG_VOL_OF_VOL: vol_of_vol   <= cfg_data[30:0];
        hpsa_pkg::CFG_SQRT_STEP:  sqrt_step    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul_op)
      hpsa_pkg::MUL_DWV: begin
        op_a = 34'(nv);
        op_b = $signed({3'b000, sqrt_step});
      end
      hpsa_pkg::MUL_DWI: begin
        op_a = 34'(ni);
        op_b = $signed({3'b000, sqrt_step});
      end
      hpsa_pkg::MUL_T1: begin
        op_a = 34'(rho);
        op_b = 34'(dw_v);
      end
      hpsa_pkg::MUL_DWS: begin
        op_a = $signed({18'd0, c});
        op_b = 34'(dw_i);
      end
      hpsa_pkg::MUL_DVA: begin
        op_a = $signed({3'b000, reversion});
        op_b = $signed({3'b000, var_target}) - $signed({2'b00, variance});
      end
      hpsa_pkg::MUL_VB: begin
        op_a = $signed({3'b000, vol_of_vol});
        op_b = $signed({2'b00, sv});
      end
      hpsa_pkg::MUL_DV: begin
        op_a = 34'(vb);
        op_b = 34'(dw_v);
      end
      hpsa_pkg::MUL_DSD: begin
        op_a = 34'(drift);
        op_b = 34'(spot);
      end
      hpsa_pkg::MUL_E: begin
        op_a = $signed({2'b00, sv});
        op_b = 34'(spot);
      end
      hpsa_pkg::MUL_DS: begin
        op_a = 34'(e);
        op_b = 34'(dw_s);
      end
      default: ;
    endcase
    abs_a = op_a[33] ? -op_a : op_a;
    abs_b = op_b[33] ? -op_b : op_b;
  end

  always_comb begin
    case (cmd.mul_op)
      hpsa_pkg::MUL_DWV, hpsa_pkg::MUL_DWI: shifted = prod >> 12;
      hpsa_pkg::MUL_T1, hpsa_pkg::MUL_DWS:  shifted = prod >> 15;
      default:                              shifted = prod >> FRAC_BITS;
    endcase
    mag = (|shifted[63:32]) ? 32'hFFFF_FFFF : shifted[31:0];
    res = prod_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    ns_sum   = 34'(spot) + 34'(ds);
    nvar_sum = $signed({2'b00, variance}) + 34'(dv);
    diff     = $signed({3'b000, strike_price}) - 34'(spot);
    pay      = diff[33] ? 32'(-diff) : diff[31:0];
    call_sum = {1'b0, call_acc} + 64'(pay);
    put_sum  = {1'b0, put_acc} + 64'(pay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_open    <= 1'b0;
      call_acc     <= '0;
      put_acc      <= '0;
      path_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.capture) begin
        nv   <= in_nv;
        ni   <= in_ni;
        rho  <= in_rho;
        pend <= in_pend;
        rend <= in_rend;
        if (!path_open) begin
          spot      <= $signed({1'b0, spot_start});
          variance  <= {1'b0, var_start};
          path_open <= 1'b1;
        end
      end
      if (cmd.store_c) c <= sq_root[15:0];
      if (cmd.store_sv) sv <= sq_root;
      if (cmd.mul_issue) begin
        prod     <= 64'(abs_a[31:0]) * 64'(abs_b[31:0]);
        prod_neg <= op_a[33] ^ op_b[33];
      end
      if (cmd.mul_write) begin
        case (cmd.mul_op)
          hpsa_pkg::MUL_DWV: dw_v <= res;
          hpsa_pkg::MUL_DWI: dw_i <= res;
          hpsa_pkg::MUL_T1:  t1   <= res;
          hpsa_pkg::MUL_DWS: dw_s <= hpsa_pkg::clamp_lim(34'(t1) + 34'(res));
          hpsa_pkg::MUL_DVA: dva  <= res;
          hpsa_pkg::MUL_VB:  vb   <= res;
          hpsa_pkg::MUL_DV:  dv   <= hpsa_pkg::clamp_lim(34'(dva) + 34'(res));
          hpsa_pkg::MUL_DSD: dsd  <= res;
          hpsa_pkg::MUL_E:   e    <= res;
          hpsa_pkg::MUL_DS:  ds   <= hpsa_pkg::clamp_lim(34'(dsd) + 34'(res));
          default: ;
        endcase
      end
      if (cmd.update) begin
        if (ns_sum > 34'sd2147483647) spot <= 32'sh7FFF_FFFF;
        else if (ns_sum < -34'sd2147483648) spot <= 32'sh8000_0000;
        else spot <= ns_sum[31:0];
        if (nvar_sum < 34'sd0) variance <= '0;
        else if (nvar_sum > hpsa_pkg::LIM) variance <= 32'hFFFF_FFFF;
        else variance <= nvar_sum[31:0];
      end
      if (cmd.payoff) begin
        if (diff < 34'sd0) call_acc <= call_sum[63] ? hpsa_pkg::ACC_MAX : call_sum[62:0];
        if (diff > 34'sd0) put_acc <= put_sum[63] ? hpsa_pkg::ACC_MAX : put_sum[62:0];
        if (path_counter != hpsa_pkg::COUNT_MAX) path_counter <= path_counter + 32'd1;
        path_open <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid    <= 1'b1;
        out_call     <= call_acc;
        out_put      <= put_acc;
        out_paths    <= path_counter;
        call_acc     <= '0;
        put_acc      <= '0;
        path_counter <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/hpsa_ctrl.sv @@
module hpsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hpsa_pkg::status_t status,
  output hpsa_pkg::cmd_t    cmd
);

  hpsa_pkg::state_t  state, state_next;
  hpsa_pkg::mul_op_t op, op_next;
  logic              phase, phase_next;

  assign in_ready = (state == hpsa_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    phase_next = phase;
    cmd        = '0;
    cmd.mul_op = op;
    case (state)
      hpsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = hpsa_pkg::ST_SQ_C;
        end
      end
      hpsa_pkg::ST_SQ_C: begin
        if (status.sq_done) begin
          cmd.store_c = 1'b1;
          state_next  = hpsa_pkg::ST_SQ_V;
        end
      end
      hpsa_pkg::ST_SQ_V: begin
        if (status.sq_done) begin
          cmd.store_sv = 1'b1;
          op_next      = hpsa_pkg::MUL_DWV;
          phase_next   = 1'b0;
          state_next   = hpsa_pkg::ST_MUL;
        end
      end
      hpsa_pkg::ST_MUL: begin
        if (!phase) begin
          cmd.mul_issue = 1'b1;
          phase_next    = 1'b1;
        end else begin
          cmd.mul_write = 1'b1;
          phase_next    = 1'b0;
          if (op == hpsa_pkg::MUL_DS) state_next = hpsa_pkg::ST_UPDATE;
          else op_next = hpsa_pkg::mul_op_t'(op + 4'd1);
        end
      end
      hpsa_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = (status.pend || status.rend) ? hpsa_pkg::ST_PAYOFF : hpsa_pkg::ST_IDLE;
      end
      hpsa_pkg::ST_PAYOFF: begin
        cmd.payoff = 1'b1;
        state_next = status.rend ? hpsa_pkg::ST_EMIT : hpsa_pkg::ST_IDLE;
      end
      hpsa_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = hpsa_pkg::ST_IDLE;
        end
      end
      default: state_next = hpsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpsa_pkg::ST_IDLE;
      op    <= hpsa_pkg::MUL_DWV;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      phase <= phase_next;
    end
  end

endmodule

@@ sv/heston_path_step_accumulator.sv @@
// Per step beat: capture, two passes of the shared bit-serial square root (32 root bits
// each, closed by a done strobe), ten products on the single shared 32x32 multiplier (each
// issued, then written back), the state update, payoff on a path or run end, and emission
// of the sums on a run end (after any wait for the result register); then back to idle.
// A new step beat is taken only in idle, once the previous one is through.
// Reset (rst, synchronous, active high): registers take their defaults, sums, path count
// and path state clear, no result is pending.
module heston_path_step_accumulator #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  hpsa_in_if.sink     steps,
  hpsa_out_if.source  totals
);

  hpsa_pkg::cmd_t    cmd;
  hpsa_pkg::status_t status;

  // Controller: sequences capture, the two root passes, the product chain, the
  // state update, payoff and emission. It takes a new step beat only when idle.
  hpsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (steps.valid),
    .in_ready (steps.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: holds configuration, spot and variance, the shared multiplier and
  // root unit, the saturating sums and the result register. The result register
  // parts the output side, so a new step is taken while a result waits.
  hpsa_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_nv     (steps.normal_var),
    .in_ni     (steps.normal_indep),
    .in_rho    (steps.correlation),
    .in_pend   (steps.path_end),
    .in_rend   (steps.run_end),
    .cmd       (cmd),
    .status    (status),
    .out_valid (totals.valid),
    .out_ready (totals.ready),
    .out_call  (totals.call_total),
    .out_put   (totals.put_total),
    .out_paths (totals.paths_total)
  );

  // emission never overwrites a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!totals.valid || totals.ready))
    else $error("result overwritten while pending");

  // an accepted step beat holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (steps.valid && steps.ready) |=> !steps.ready)
    else $error("step beat accepted while busy");

  // a result only appears after an emission
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(totals.valid) |-> $past(cmd.emit))
    else $error("result valid without emission");

  // products are only issued while no step is being captured
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_issue |-> !steps.ready)
    else $error("multiplier active while idle");

endmodule
